>>> sv/tfc_pkg.sv
// Package for the serial frame codec: beat structs, stage structs, codes and
// the bit-reversal helper of the align and check stages. Depends on nothing.
`default_nettype none

package tfc_pkg;

   localparam int WordWidth  = 16;
   localparam int ByteWidth  = 8;
   localparam int CountWidth = 5;

   localparam logic OP_ENCODE = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_PARITY = 2'd1;
   localparam logic [1:0] STATUS_STOP   = 2'd2;

   localparam logic [3:0] FRAME_PAD = 4'hf;
   localparam logic       START_BIT = 1'b0;
   localparam logic [1:0] STOP_PAIR = 2'b11;

   typedef struct packed {
      logic                   operation;
      logic [ByteWidth-1:0]   tx_byte;
      logic [WordWidth-1:0]   rx_word;
   } req_type;

   typedef struct packed {
      logic [WordWidth-1:0]   frame_word;
      logic [ByteWidth-1:0]   rx_byte;
      logic [1:0]             status;
   } rsp_type;

   typedef struct packed {
      logic                   valid;
      logic                   operation;
      logic [ByteWidth-1:0]   tx_byte;
      logic [WordWidth-1:0]   rx_word;
      logic [CountWidth-1:0]  lead_count;
   } lead_stage_type;

   typedef struct packed {
      logic                   valid;
      logic                   operation;
      logic [WordWidth-1:0]   frame_word;
      logic [WordWidth-1:0]   aligned_word;
   } align_stage_type;

   function automatic logic [ByteWidth-1:0] bit_flip8(input logic [ByteWidth-1:0] v);
      logic [ByteWidth-1:0] r;
      for (int i = 0; i < ByteWidth; i++) begin
         r[i] = v[ByteWidth-1-i];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> sv/tpi_frame_codec.sv
// Top level of the serial frame codec: three-stage pipeline of leading-ones
// count, alignment and encode, then byte extraction and checks.
// An accepted beat is registered in the lead, align and check stages in turn.
// Throughput: one beat per cycle; busy is never raised.
// Reset clears the stage valid bits only; results cannot be stalled.
// Depends on tfc_pkg, tfc_lead_count, tfc_align, tfc_check and tfc_rsp_checker.
`default_nettype none

module tpi_frame_codec
   import tfc_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   output logic          busy,
   input  wire req_type  req_data,
   output logic          rsp_valid,
   output rsp_type       rsp_data
);

   lead_stage_type  lead_stage;
   align_stage_type align_stage;
   logic            accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   tfc_lead_count u_lead_count (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .stage_out (lead_stage)
   );

   tfc_align u_align (
      .clock     (clock),
      .reset     (reset),
      .stage_in  (lead_stage),
      .stage_out (align_stage)
   );

   tfc_check u_check (
      .clock     (clock),
      .reset     (reset),
      .stage_in  (align_stage),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   tfc_rsp_checker u_rsp_checker (
      .clock     (clock),
      .reset     (reset),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assert property (@(posedge clock) disable iff (reset)
      accept |-> ##3 rsp_valid)
      else $error("Accepted beat did not produce a result three cycles later.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(lead_stage.valid, 2))
      else $error("Result strobe without a beat in the first stage.");

   assert property (@(posedge clock) disable iff (reset)
      (lead_stage.valid && lead_stage.operation == OP_DECODE &&
       lead_stage.rx_word == '1) |-> (lead_stage.lead_count == CountWidth'(WordWidth)))
      else $error("All-ones word did not count sixteen leading ones.");

endmodule

`default_nettype wire

>>> sv/tfc_lead_count.sv
// First pipeline stage: registers the request beat and counts the leading
// ones of the received word. Depends on tfc_pkg.
`default_nettype none

module tfc_lead_count
   import tfc_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           accept,
   input  wire req_type        req_data,
   output lead_stage_type      stage_out
);

   logic                  valid_ff;
   req_type               req_ff;
   logic [CountWidth-1:0] lead_ff;
   logic [CountWidth-1:0] lead_in;

   // The highest zero bit decides the count; an all-ones word counts sixteen.
   always_comb begin
      lead_in = CountWidth'(WordWidth);
      for (int i = 0; i < WordWidth; i++) begin
         if (!req_data.rx_word[i]) begin
            lead_in = CountWidth'(WordWidth - 1 - i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_data;
      lead_ff <= lead_in;
   end

   always_comb begin
      stage_out.valid      = valid_ff;
      stage_out.operation  = req_ff.operation;
      stage_out.tx_byte    = req_ff.tx_byte;
      stage_out.rx_word    = req_ff.rx_word;
      stage_out.lead_count = lead_ff;
   end

endmodule

`default_nettype wire

>>> sv/tfc_align.sv
// Second pipeline stage: shifts the received word past its leading ones and
// builds the encoded frame. Depends on tfc_pkg.
`default_nettype none

module tfc_align
   import tfc_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire lead_stage_type  stage_in,
   output align_stage_type      stage_out
);

   logic                 valid_ff;
   logic                 operation_ff;
   logic [WordWidth-1:0] frame_ff;
   logic [WordWidth-1:0] frame_in;
   logic [WordWidth-1:0] aligned_ff;
   logic [WordWidth-1:0] aligned_in;

   always_comb begin
      aligned_in = stage_in.rx_word << stage_in.lead_count;
      frame_in   = {FRAME_PAD, START_BIT, bit_flip8(stage_in.tx_byte),
                    ^stage_in.tx_byte, STOP_PAIR};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      operation_ff <= stage_in.operation;
      frame_ff     <= frame_in;
      aligned_ff   <= aligned_in;
   end

   always_comb begin
      stage_out.valid        = valid_ff;
      stage_out.operation    = operation_ff;
      stage_out.frame_word   = frame_ff;
      stage_out.aligned_word = aligned_ff;
   end

endmodule

`default_nettype wire

>>> sv/tfc_check.sv
// Third pipeline stage: passes the encoded frame, or extracts the data byte,
// checks parity and stop bits; registers the result beat. Depends on tfc_pkg.
`default_nettype none

module tfc_check
   import tfc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire align_stage_type  stage_in,
   output logic                  rsp_valid,
   output rsp_type               rsp_data
);

   logic                 valid_ff;
   rsp_type              rsp_ff;
   rsp_type              rsp_in;
   logic [ByteWidth-1:0] data;

   always_comb begin
      data   = bit_flip8(stage_in.aligned_word[14:7]);
      rsp_in = '0;
      unique case (stage_in.operation)
         OP_ENCODE: begin
            rsp_in.frame_word = stage_in.frame_word;
         end
         OP_DECODE: begin
            rsp_in.rx_byte = data;
            priority if ((^data) != stage_in.aligned_word[6]) begin
               rsp_in.status = STATUS_PARITY;
            end else if (stage_in.aligned_word[5:4] != STOP_PAIR) begin
               rsp_in.status = STATUS_STOP;
            end else begin
               rsp_in.status = STATUS_OK;
            end
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

>>> sv/tfc_frame_codec_top_dummy_guard.sv
// Result-side checks for the serial frame codec, watching the result ports
// only. Depends on tfc_pkg.
`default_nettype none

module tfc_rsp_checker
   import tfc_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     rsp_valid,
   input  wire rsp_type  rsp_data
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == STATUS_OK || rsp_data.status == STATUS_PARITY ||
                     rsp_data.status == STATUS_STOP))
      else $error("Result beat carries an undefined status code.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.frame_word != '0) |->
         (rsp_data.rx_byte == '0 && rsp_data.status == STATUS_OK))
      else $error("Encoded beat carries decode fields.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.frame_word != '0) |->
         (rsp_data.frame_word[15:11] == {FRAME_PAD, START_BIT} &&
          rsp_data.frame_word[1:0] == STOP_PAIR))
      else $error("Encoded frame has a malformed pad, start or stop field.");

endmodule

`default_nettype wire
